### sv/touch_sample_qualify_and_map_core_macros.svh
// assertion macros for the touch sample qualify and map core
`ifndef TOUCH_SAMPLE_QUALIFY_AND_MAP_CORE_MACROS_SVH
`define TOUCH_SAMPLE_QUALIFY_AND_MAP_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TSQM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TSQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tsqm_pkg.sv
// shared constants and types for the touch sample qualify and map core
package tsqm_pkg;

  // screen and qualification constants
  localparam int VIEW_W          = 320;
  localparam int VIEW_H          = 240;
  localparam int DEADBAND        = 20;
  localparam int ATTEMPTS        = 5;
  localparam int HOLD_MS         = 50;
  localparam int RESET_THRESHOLD = 350;
  localparam int MIN_THRESHOLD   = 20;

  // orientation bits
  localparam int ORIENT_SWAP  = 0;
  localparam int ORIENT_INV_X = 1;
  localparam int ORIENT_INV_Y = 2;

  // datapath widths
  localparam int RAW_W     = 16;
  localparam int VIEW_MAX  = (VIEW_W > VIEW_H) ? VIEW_W : VIEW_H;
  localparam int VIEW_BITS = $clog2(VIEW_MAX + 1);
  localparam int PROD_W    = RAW_W + VIEW_BITS;
  localparam int CNT_W     = $clog2(PROD_W + 1);

  // register indexes of the config port
  typedef enum logic [2:0] {
    CFG_X_OFFSET    = 3'd0,
    CFG_X_SPAN      = 3'd1,
    CFG_Y_OFFSET    = 3'd2,
    CFG_Y_SPAN      = 3'd3,
    CFG_ORIENT_MODE = 3'd4,
    CFG_PRESS_THR   = 3'd5
  } cfg_idx_t;

  // sample phase codes within one attempt
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [RAW_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/tsqm_ifs.sv
// handshake interfaces for samples, results and config writes

// raw panel sample channel
interface tsqm_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_x;
  logic [15:0] raw_y;
  logic [15:0] raw_z;
  logic [31:0] now_ms;

  modport source (output valid, raw_x, raw_y, raw_z, now_ms, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, now_ms, output ready);
endinterface

// touch result channel
interface tsqm_result_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic [8:0] touch_x;
  logic [7:0] touch_y;

  modport source (output valid, pressed, touch_x, touch_y, input ready);
  modport sink   (input valid, pressed, touch_x, touch_y, output ready);
endinterface

// config register write channel
interface tsqm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/tsqm_div.sv
// serial restoring divider, one quotient bit per cycle
module tsqm_div (
  input  logic              clk,
  input  logic              rst,
  input  tsqm_pkg::div_req_t req,
  output tsqm_pkg::div_rsp_t rsp
);

  logic [tsqm_pkg::PROD_W-1:0] quo;
  logic [tsqm_pkg::RAW_W-1:0]  rem;
  logic [tsqm_pkg::RAW_W-1:0]  dvs;
  logic [tsqm_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic                        done;

  logic [tsqm_pkg::RAW_W:0]    rem_sh;
  logic [tsqm_pkg::RAW_W+1:0]  diff;
  logic                        ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quo[tsqm_pkg::PROD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    ge     = ~diff[tsqm_pkg::RAW_W+1];
  end

  // control: run until every dividend bit has been shifted through
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= tsqm_pkg::CNT_W'(tsqm_pkg::PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tsqm_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[tsqm_pkg::RAW_W-1:0] : rem_sh[tsqm_pkg::RAW_W-1:0];
      quo <= {quo[tsqm_pkg::PROD_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### sv/touch_sample_qualify_and_map_core.sv
// top level: sample qualification, hold deadline and calibrated screen mapping
//
//   channel  dir  handshake      payload
//   sample   in   valid / ready  raw_x, raw_y, raw_z, now_ms
//   result   out  valid / ready  pressed, touch_x, touch_y
//   cfg      in   valid / ready  index, data (ready always high)
//
// a sample that does not end an update is taken back to back while the sequencer is idle.
// a sample that ends an update with a pass holds the input off while both axes map:
// per axis a start state, a wait for the divider and a fix-up state, then a load.
// an update with no passing attempt holds the input off only for the load.
// a new result waits for the result register to empty; samples are held off meanwhile.
// rst is synchronous and restores the register defaults and the attempt state.
`include "touch_sample_qualify_and_map_core_macros.svh"

module touch_sample_qualify_and_map_core (
  input logic            clk,
  input logic            rst,
  tsqm_sample_if.sink    sample,
  tsqm_result_if.source  result,
  tsqm_cfg_if.sink       cfg
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // config registers
  logic [15:0] x_offset, x_span, y_offset, y_span, press_threshold;
  logic [2:0]  orient_mode;

  // qualification state
  logic [2:0]  attempt_index;
  logic [1:0]  sample_phase;
  logic [15:0] first_x, first_y, latched_x, latched_y;
  logic [2:0]  pass_count;
  logic [15:0] active_threshold;
  logic [31:0] hold_deadline;

  // mapping sequencer
  state_t      st;
  logic        axis;
  logic        neg;
  logic        zero_res;
  logic [15:0] mx, my;

  // result register
  logic        out_valid;
  logic        out_pressed;
  logic [8:0]  out_x;
  logic [7:0]  out_y;

  tsqm_pkg::div_req_t div_req;
  tsqm_pkg::div_rsp_t div_rsp;

  logic        accept;
  logic        start_upd;
  logic [15:0] thr_cfg, thr_use;
  logic        low_z;
  logic [16:0] dx, dy;
  logic [15:0] adx, ady;
  logic        near;
  logic        attempt_done;
  logic        attempt_pass;
  logic [2:0]  attempt_next;
  logic        last;
  logic [2:0]  pass_next;
  logic [1:0]  sample_phase_next;
  logic [15:0] active_threshold_next;

  logic [15:0] map_raw, map_off, map_span;
  logic [16:0] map_d;
  logic [15:0] map_mag;
  logic [15:0] view16;
  logic [15:0] q16, sv_val, fix_val;
  logic        map_inv;
  logic        out_free;
  logic        in_view;
  logic        out_in_view;
  logic        out_blank;

  assign accept   = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  // config writes, taken every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset        <= 16'd1;
      x_span          <= 16'd1;
      y_offset        <= 16'd1;
      y_span          <= 16'd1;
      orient_mode     <= 3'd0;
      press_threshold <= 16'(tsqm_pkg::RESET_THRESHOLD);
    end else if (cfg.valid && cfg.ready) begin
      unique case (tsqm_pkg::cfg_idx_t'(cfg.index))
        tsqm_pkg::CFG_X_OFFSET:    x_offset        <= cfg.data;
        tsqm_pkg::CFG_X_SPAN:      x_span          <= cfg.data;
        tsqm_pkg::CFG_Y_OFFSET:    y_offset        <= cfg.data;
        tsqm_pkg::CFG_Y_SPAN:      y_span          <= cfg.data;
        tsqm_pkg::CFG_ORIENT_MODE: orient_mode     <= cfg.data[2:0];
        tsqm_pkg::CFG_PRESS_THR:   press_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // threshold pick and per-sample checks
  always_comb begin
    start_upd = (attempt_index == 3'd0) && (sample_phase == tsqm_pkg::PH_FIRST);
    thr_cfg   = (press_threshold < 16'(tsqm_pkg::MIN_THRESHOLD)) ?
                16'(tsqm_pkg::MIN_THRESHOLD) : press_threshold;
    active_threshold_next = (hold_deadline > sample.now_ms) ?
                            16'(tsqm_pkg::MIN_THRESHOLD) : thr_cfg;
    thr_use = start_upd ? active_threshold_next : active_threshold;
    low_z   = sample.raw_z <= thr_use;

    dx   = {1'b0, sample.raw_x} - {1'b0, first_x};
    dy   = {1'b0, sample.raw_y} - {1'b0, first_y};
    adx  = dx[16] ? 16'(-dx) : dx[15:0];
    ady  = dy[16] ? 16'(-dy) : dy[15:0];
    near = (adx <= 16'(tsqm_pkg::DEADBAND)) && (ady <= 16'(tsqm_pkg::DEADBAND));

    attempt_done      = 1'b0;
    attempt_pass      = 1'b0;
    sample_phase_next = sample_phase;
    priority if (sample_phase == tsqm_pkg::PH_FIRST) begin
      if (low_z) attempt_done = 1'b1;
      else sample_phase_next = tsqm_pkg::PH_SECOND;
    end else if (sample_phase == tsqm_pkg::PH_SECOND) begin
      if (low_z) attempt_done = 1'b1;
      else sample_phase_next = tsqm_pkg::PH_THIRD;
    end else begin
      attempt_pass = near;
      attempt_done = 1'b1;
    end
    if (attempt_done) sample_phase_next = tsqm_pkg::PH_FIRST;

    attempt_next = attempt_index + 3'd1;
    last         = attempt_done && (attempt_next >= 3'(tsqm_pkg::ATTEMPTS));
    pass_next    = pass_count + {2'b00, attempt_pass};
  end

  // qualification state, updated per accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_index    <= 3'd0;
      sample_phase     <= tsqm_pkg::PH_FIRST;
      first_x          <= 16'd0;
      first_y          <= 16'd0;
      latched_x        <= 16'd0;
      latched_y        <= 16'd0;
      pass_count       <= 3'd0;
      active_threshold <= 16'd0;
      hold_deadline    <= 32'd0;
    end else if (accept) begin
      if (start_upd) active_threshold <= active_threshold_next;
      sample_phase <= sample_phase_next;
      if (sample_phase == tsqm_pkg::PH_FIRST && !low_z) begin
        first_x <= sample.raw_x;
        first_y <= sample.raw_y;
      end
      if (attempt_pass) begin
        latched_x <= first_x;
        latched_y <= first_y;
      end
      if (last) begin
        attempt_index <= 3'd0;
        pass_count    <= 3'd0;
        hold_deadline <= (pass_next == 3'd0) ? 32'd0 :
                         sample.now_ms + 32'(tsqm_pkg::HOLD_MS);
      end else begin
        if (attempt_done) attempt_index <= attempt_next;
        pass_count <= pass_next;
      end
    end
  end

  // axis operands: offset removal, magnitude and sign
  always_comb begin
    map_raw  = (orient_mode[tsqm_pkg::ORIENT_SWAP] ^ axis) ? latched_y : latched_x;
    map_off  = axis ? y_offset : x_offset;
    map_span = axis ? y_span : x_span;
    if (map_off == 16'd0) map_off = 16'd1;
    if (map_span == 16'd0) map_span = 16'd1;
    view16   = axis ? 16'(tsqm_pkg::VIEW_H) : 16'(tsqm_pkg::VIEW_W);
    map_inv  = axis ? orient_mode[tsqm_pkg::ORIENT_INV_Y] :
                      orient_mode[tsqm_pkg::ORIENT_INV_X];
    map_d    = {1'b0, map_raw} - {1'b0, map_off};
    map_mag  = map_d[16] ? 16'(-map_d) : map_d[15:0];

    div_req.start    = (st == ST_MUL);
    div_req.dividend = tsqm_pkg::PROD_W'(map_mag) *
                       tsqm_pkg::PROD_W'(axis ? tsqm_pkg::VIEW_H : tsqm_pkg::VIEW_W);
    div_req.divisor  = map_span;

    // sign back on, wrap to 16 bits, optional invert
    q16     = div_rsp.quotient[15:0];
    sv_val  = neg ? 16'(-q16) : q16;
    fix_val = map_inv ? 16'(view16 - sv_val) : sv_val;

    in_view = (mx < 16'(tsqm_pkg::VIEW_W)) && (my < 16'(tsqm_pkg::VIEW_H));
  end

  tsqm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // mapping sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      axis <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (accept && last) begin
            axis <= 1'b0;
            st   <= (pass_next == 3'd0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL:  st <= ST_DIV;
        ST_DIV:  if (div_rsp.done) st <= ST_FIX;
        ST_FIX: begin
          if (axis) begin
            st <= ST_FIN;
          end else begin
            axis <= 1'b1;
            st   <= ST_MUL;
          end
        end
        ST_FIN:  if (out_free) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && accept && last) zero_res <= (pass_next == 3'd0);
    if (st == ST_MUL) neg <= map_d[16];
    if (st == ST_FIX) begin
      if (axis) my <= fix_val;
      else mx <= fix_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_FIN && out_free) begin
      if (zero_res || !in_view) begin
        out_pressed <= 1'b0;
        out_x       <= 9'd0;
        out_y       <= 8'd0;
      end else begin
        out_pressed <= 1'b1;
        out_x       <= mx[8:0];
        out_y       <= my[7:0];
      end
    end
  end

  assign sample.ready   = (st == ST_IDLE);
  assign result.valid   = out_valid;
  assign result.pressed = out_pressed;
  assign result.touch_x = out_x;
  assign result.touch_y = out_y;

  // result register contents seen by the checks
  assign out_in_view = (out_x < 9'(tsqm_pkg::VIEW_W)) && (out_y < 8'(tsqm_pkg::VIEW_H));
  assign out_blank   = (out_x == 9'd0) && (out_y == 8'd0);

  // checks
  `TSQM_ASSERT_NOW(a_div_done_in_div, div_rsp.done, st == ST_DIV, "divider done outside wait")
  `TSQM_ASSERT_NEXT(a_mul_then_div, st == ST_MUL, st == ST_DIV && div_rsp.busy, "no divide")
  `TSQM_ASSERT_NOW(a_pressed_in_view, out_valid && out_pressed, out_in_view, "pressed off view")
  `TSQM_ASSERT_NOW(a_released_zero, out_valid && !out_pressed, out_blank, "released with point")

endmodule

### tb/sv/touch_sample_qualify_and_map_core_test.sv
// testbench for the touch sample qualify and map core, checked against a predictor
module touch_sample_qualify_and_map_core_test;
  import tsqm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 100;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int MAX_PRINTED    = 40;

  // indexes past the register file, the block ignores them
  localparam logic [2:0] CFG_RESERVED_LO = 3'd6;
  localparam logic [2:0] CFG_RESERVED_HI = 3'd7;

  // orientation register values
  localparam logic [15:0] OR_NONE  = 16'd0;
  localparam logic [15:0] OR_SWAP  = 16'(1 << ORIENT_SWAP);
  localparam logic [15:0] OR_INV_X = 16'(1 << ORIENT_INV_X);
  localparam logic [15:0] OR_INV_Y = 16'(1 << ORIENT_INV_Y);

  typedef enum int {TRY_PASS, TRY_LOW_FIRST, TRY_LOW_SECOND, TRY_DRIFT} try_kind_t;

  typedef struct packed {
    logic       pressed;
    logic [8:0] touch_x;
    logic [7:0] touch_y;
  } touch_t;

  logic clk = 1'b0;
  logic rst;

  tsqm_sample_if sample_ch ();
  tsqm_result_if result_ch ();
  tsqm_cfg_if    cfg_ch ();

  touch_sample_qualify_and_map_core dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // calibration registers as the predictor sees them
  logic [15:0] cal_x_off, cal_x_span, cal_y_off, cal_y_span, cal_thr;
  logic [2:0]  cal_orient;

  // qualification state of the predictor
  logic [2:0]  attempt_no;
  logic [1:0]  attempt_phase;
  logic [15:0] anchor_x, anchor_y;
  logic [15:0] hit_x, hit_y;
  logic [2:0]  hit_count;
  logic [15:0] live_threshold;
  logic [31:0] hold_until;

  touch_t      expected_touches[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          tx_calm_left = 0;
  int          result_hold_cycles = 0;
  logic [31:0] clock_ms = 32'd0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("touch_sample_qualify_and_map_core regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    cal_x_off      = 16'd1;
    cal_x_span     = 16'd1;
    cal_y_off      = 16'd1;
    cal_y_span     = 16'd1;
    cal_orient     = 3'd0;
    cal_thr        = 16'(RESET_THRESHOLD);
    attempt_no     = '0;
    attempt_phase  = PH_FIRST;
    anchor_x       = '0;
    anchor_y       = '0;
    hit_x          = '0;
    hit_y          = '0;
    hit_count      = '0;
    live_threshold = '0;
    hold_until     = '0;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [15:0] value);
    case (idx)
      CFG_X_OFFSET:    cal_x_off  = value;
      CFG_X_SPAN:      cal_x_span = value;
      CFG_Y_OFFSET:    cal_y_off  = value;
      CFG_Y_SPAN:      cal_y_span = value;
      CFG_ORIENT_MODE: cal_orient = value[2:0];
      CFG_PRESS_THR:   cal_thr    = value;
      default: ;
    endcase
  endfunction

  // threshold picked at the start of an update
  function automatic logic [15:0] start_threshold(input logic [31:0] now);
    logic [15:0] th;
    th = (cal_thr < MIN_THRESHOLD) ? 16'(MIN_THRESHOLD) : cal_thr;
    if (hold_until > now)
      th = 16'(MIN_THRESHOLD);
    return th;
  endfunction

  // threshold that a sample at this time will meet
  function automatic logic [15:0] threshold_for(input logic [31:0] now);
    if (attempt_no == 0 && attempt_phase == PH_FIRST)
      return start_threshold(now);
    return live_threshold;
  endfunction

  function automatic bit within_deadband(input logic [15:0] a, input logic [15:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0)
      d = -d;
    return d <= DEADBAND;
  endfunction

  // signed offset and scale, truncating division, 16-bit wrap, optional flip
  function automatic logic [15:0] scale_axis(input logic [15:0] raw, input logic [15:0] off,
                                             input logic [15:0] span, input int view,
                                             input bit flip);
    longint diff, quo;
    logic [15:0] v;
    diff = longint'(raw) - longint'((off == 16'd0) ? 16'd1 : off);
    quo  = (diff * view) / longint'((span == 16'd0) ? 16'd1 : span);
    v    = quo[15:0];
    if (flip)
      v = 16'(view) - v;
    return v;
  endfunction

  // advance the predictor by one accepted sample
  task automatic qualify_sample(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z, input logic [31:0] now);
    touch_t      r;
    logic [15:0] sx, sy, mx, my;
    bit          done;
    done = 1'b0;
    if (attempt_no == 0 && attempt_phase == PH_FIRST)
      live_threshold = start_threshold(now);
    case (attempt_phase)
      PH_FIRST: begin
        if (z <= live_threshold) begin
          done = 1'b1;
        end else begin
          anchor_x      = x;
          anchor_y      = y;
          attempt_phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (z <= live_threshold)
          done = 1'b1;
        else
          attempt_phase = PH_THIRD;
      end
      default: begin
        if (within_deadband(anchor_x, x) && within_deadband(anchor_y, y)) begin
          hit_x     = anchor_x;
          hit_y     = anchor_y;
          hit_count = hit_count + 3'd1;
        end
        done = 1'b1;
      end
    endcase
    if (done) begin
      attempt_phase = PH_FIRST;
      attempt_no    = attempt_no + 3'd1;
      if (attempt_no >= ATTEMPTS) begin
        attempt_no = '0;
        r          = '0;
        if (hit_count == 0) begin
          hold_until = '0;
        end else begin
          hit_count  = '0;
          hold_until = now + 32'(HOLD_MS);
          sx = cal_orient[ORIENT_SWAP] ? hit_y : hit_x;
          sy = cal_orient[ORIENT_SWAP] ? hit_x : hit_y;
          mx = scale_axis(sx, cal_x_off, cal_x_span, VIEW_W, cal_orient[ORIENT_INV_X]);
          my = scale_axis(sy, cal_y_off, cal_y_span, VIEW_H, cal_orient[ORIENT_INV_Y]);
          if (mx < VIEW_W && my < VIEW_H) begin
            r.pressed = 1'b1;
            r.touch_x = mx[8:0];
            r.touch_y = my[7:0];
          end
        end
        expected_touches.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one sample request and wait until it is taken
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [31:0] now);
    int gap;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 3)
        tx_calm_left = 40;
    end
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.raw_x  <= x;
    sample_ch.raw_y  <= y;
    sample_ch.raw_z  <= z;
    sample_ch.now_ms <= now;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    qualify_sample(x, y, z, now);
    items_sent++;
  endtask

  // drop the sample request and let every pending touch come out
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (expected_touches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    store_reg(idx, value);
  endtask

  task automatic apply_calibration(input logic [15:0] xo, input logic [15:0] xs,
                                   input logic [15:0] yo, input logic [15:0] ys,
                                   input logic [15:0] om, input logic [15:0] th);
    wait_idle();
    write_reg(CFG_X_OFFSET, xo);
    write_reg(CFG_X_SPAN, xs);
    write_reg(CFG_Y_OFFSET, yo);
    write_reg(CFG_Y_SPAN, ys);
    write_reg(CFG_ORIENT_MODE, om);
    write_reg(CFG_PRESS_THR, th);
    write_reg(CFG_RESERVED_LO, 16'($urandom));
    write_reg(CFG_RESERVED_HI, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // sample clock: mostly close together, sometimes past the hold, rarely a jump
  function automatic logic [31:0] next_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      clock_ms = clock_ms + $urandom_range(0, 3);
    else if (r < 90)
      clock_ms = clock_ms + $urandom_range(4, 40);
    else if (r < 97)
      clock_ms = clock_ms + $urandom_range(41, 120);
    else if (r < 99)
      clock_ms = $urandom;
    else
      clock_ms = 32'hFFFF_FFC0 + $urandom_range(0, 40);
    return clock_ms;
  endfunction

  // pressure above or at-or-below the threshold, often right on the edge
  function automatic logic [15:0] pick_press(input logic [15:0] th, input bit above);
    if (above) begin
      if (th == 16'hFFFF)
        return th;
      if ($urandom_range(0, 4) == 0)
        return th + 16'd1;
      return 16'($urandom_range(int'(th) + 1, 65535));
    end
    if ($urandom_range(0, 4) == 0)
      return th;
    return 16'($urandom_range(0, int'(th)));
  endfunction

  // raw reading around the calibrated window of one axis
  function automatic logic [15:0] pick_raw(input logic [15:0] off, input logic [15:0] span);
    int o, s, v, r;
    o = (off == 16'd0) ? 1 : int'(off);
    s = (span == 16'd0) ? 1 : int'(span);
    r = $urandom_range(0, 99);
    if (r < 72)
      v = o + int'($urandom_range(0, s));
    else if (r < 84)
      v = o - int'($urandom_range(0, s / VIEW_W + 1));
    else if (r < 92)
      v = o + s + int'($urandom_range(0, 300));
    else
      v = int'($urandom_range(0, 65535));
    if (v < 0)
      v = 0;
    if (v > 65535)
      v = 65535;
    return 16'(v);
  endfunction

  function automatic int jitter();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? DEADBAND : -DEADBAND;
    return int'($urandom_range(0, 2 * DEADBAND)) - DEADBAND;
  endfunction

  function automatic int drift();
    int d;
    d = int'($urandom_range(DEADBAND + 1, DEADBAND + 600));
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  // one attempt of up to three samples starting at (x, y)
  task automatic send_attempt(input try_kind_t kind, input logic [15:0] x, input logic [15:0] y);
    logic [31:0] now;
    logic [15:0] th;
    int          dx, dy, pick;
    now = next_ms();
    th  = threshold_for(now);
    if (kind == TRY_LOW_FIRST) begin
      send_sample(x, y, pick_press(th, 1'b0), now);
    end else begin
      send_sample(x, y, pick_press(th, 1'b1), now);
      th = live_threshold;
      if (kind == TRY_LOW_SECOND) begin
        send_sample(rnd16(), rnd16(), pick_press(th, 1'b0), next_ms());
      end else begin
        send_sample(rnd16(), rnd16(), pick_press(th, 1'b1), next_ms());
        if (kind == TRY_PASS) begin
          dx = jitter();
          dy = jitter();
        end else begin
          pick = $urandom_range(0, 2);
          dx   = (pick != 1) ? drift() : jitter();
          dy   = (pick != 0) ? drift() : jitter();
        end
        send_sample(16'(int'(x) + dx), 16'(int'(y) + dy), rnd16(), next_ms());
      end
    end
  endtask

  // one full update of attempts with random outcomes
  task automatic run_update(input int pass_pct);
    logic [15:0] px, py;
    try_kind_t   kind;
    int          r;
    for (int i = 0; i < ATTEMPTS; i++) begin
      r = $urandom_range(0, 99);
      if (r < pass_pct)
        kind = TRY_PASS;
      else if (r % 3 == 0)
        kind = TRY_LOW_FIRST;
      else if (r % 3 == 1)
        kind = TRY_LOW_SECOND;
      else
        kind = TRY_DRIFT;
      px = pick_raw(cal_x_off, cal_x_span);
      py = pick_raw(cal_y_off, cal_y_span);
      if (cal_orient[ORIENT_SWAP])
        send_attempt(kind, py, px);
      else
        send_attempt(kind, px, py);
    end
  endtask

  task automatic run_updates(input int count, input int pass_pct);
    int target;
    target = items_sent + count;
    while (items_sent < target)
      run_update(pass_pct);
  endtask

  // ---------------------------------------------------------------- tests

  // reset calibration: threshold edges, deadband edges, deadline wrap and forced threshold
  task automatic test_directed_edges();
    // no attempt passes, pressure at or under the threshold
    send_sample(16'hFFFF, 16'hFFFF, 16'h0000, 32'd0);
    send_sample(16'h0000, 16'h0000, 16'(RESET_THRESHOLD), 32'd1);
    send_sample(16'h1234, 16'hABCD, 16'(RESET_THRESHOLD), 32'd2);
    send_sample(16'h0000, 16'hFFFF, 16'd100, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 32'd4);
    // pass right at the deadband, the rest fail on the second sample, deadline wraps
    send_sample(16'd1, 16'd1, 16'(RESET_THRESHOLD + 1), 32'hFFFF_FFF0);
    send_sample(16'd7, 16'd7, 16'hFFFF, 32'hFFFF_FFF1);
    send_sample(16'(1 + DEADBAND), 16'(1 + DEADBAND), 16'd0, 32'hFFFF_FFF2);
    for (int i = 0; i < ATTEMPTS - 1; i++) begin
      send_sample(16'd100, 16'd100, 16'hFFFF, 32'hFFFF_FFF3 + 32'(2 * i));
      send_sample(16'd100, 16'd100, 16'(RESET_THRESHOLD), 32'hFFFF_FFF4 + 32'(2 * i));
    end
    // hold running: minimum threshold, drift just past deadband, out-of-view pass
    send_sample(16'd500, 16'd500, 16'(MIN_THRESHOLD + 1), 32'h10);
    send_sample(16'd500, 16'd500, 16'(MIN_THRESHOLD + 1), 32'h11);
    send_sample(16'(500 + DEADBAND + 1), 16'd500, 16'd0, 32'h12);
    send_sample(16'd2, 16'd2, 16'(MIN_THRESHOLD + 1), 32'h13);
    send_sample(16'd2, 16'd2, 16'hFFFF, 32'h14);
    send_sample(16'd2, 16'd2, 16'd0, 32'h15);
    for (int i = 0; i < ATTEMPTS - 2; i++)
      send_sample(16'd2, 16'd2, 16'(MIN_THRESHOLD), 32'h16 + 32'(i));
    clock_ms = 32'h20;
  endtask

  // calibration settings: orientations, zero and full registers, threshold clamp
  task automatic test_calibration_sweep();
    apply_calibration(16'd300, 16'd3600, 16'd250, 16'd3500, OR_NONE, 16'd350);
    run_updates(70, 45);
    apply_calibration(16'd300, 16'd3600, 16'd250, 16'd3500, OR_SWAP, 16'd19);
    run_updates(70, 45);
    apply_calibration(16'd300, 16'd3600, 16'd250, 16'd3500, OR_INV_X, 16'd0);
    run_updates(70, 45);
    apply_calibration(16'd200, 16'd3800, 16'd150, 16'd3900, OR_INV_Y, 16'(MIN_THRESHOLD));
    run_updates(70, 45);
    apply_calibration(16'd200, 16'd3800, 16'd150, 16'd3900, OR_SWAP | OR_INV_X | OR_INV_Y,
                      16'(MIN_THRESHOLD + 1));
    run_updates(70, 45);
    apply_calibration(16'd0, 16'd0, 16'd0, 16'd0, OR_NONE, 16'd500);
    run_updates(70, 45);
    apply_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, OR_SWAP, 16'd100);
    run_updates(70, 45);
    // upper orientation bits set, threshold at full scale
    apply_calibration(16'd1000, 16'hFFFF, 16'd5, 16'd30000, 16'hFFF8 | OR_INV_X | OR_INV_Y,
                      16'hFFFF);
    run_updates(70, 45);
    apply_calibration(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
    run_updates(70, 45);
    for (int i = 0; i < 2; i++) begin
      apply_calibration(16'($urandom_range(0, 1000)), 16'($urandom_range(2000, 4000)),
                        16'($urandom_range(0, 1000)), 16'($urandom_range(2000, 4000)),
                        rnd16(), 16'($urandom_range(0, 600)));
      run_updates(70, 45);
    end
  endtask

  // unstructured samples and broken attempts
  task automatic test_sample_noise();
    logic [31:0] now;
    logic [15:0] z;
    apply_calibration(16'd300, 16'd3600, 16'd250, 16'd3500, 16'($urandom_range(0, 7)),
                      16'($urandom_range(0, 600)));
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        clock_ms = $urandom;
        now = clock_ms;
      end else begin
        now = next_ms();
      end
      if ($urandom_range(0, 1))
        z = rnd16();
      else
        z = pick_press(threshold_for(now), 1'($urandom_range(0, 1)));
      send_sample(rnd16(), rnd16(), z, now);
    end
  endtask

  // receiver holds off long enough that the block stops taking samples
  task automatic test_result_backpressure();
    apply_calibration(16'd300, 16'd3600, 16'd250, 16'd3500, OR_NONE, 16'd200);
    result_hold_cycles = 600;
    run_updates(130, 80);
  endtask

  // ---------------------------------------------------------------- result side

  // result ready with random stalls, calm stretches and the long hold-off
  initial begin : result_sink
    int stall_left, calm_left;
    stall_left = 0;
    calm_left  = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        result_hold_cycles--;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (calm_left > 0)
          calm_left--;
        else if ($urandom_range(0, 99) < 25)
          stall_left = pick_gap();
        else if ($urandom_range(0, 99) < 2)
          calm_left = 300;
      end
    end
  end

  // compare each delivered touch with the oldest prediction
  always @(posedge clk) begin : check_touch
    touch_t want;
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_touches.size() == 0) begin
        report_mismatch("touch result with nothing pending", 1, 0);
      end else begin
        want = expected_touches.pop_front();
        if (result_ch.pressed !== want.pressed)
          report_mismatch("pressed", int'(result_ch.pressed), int'(want.pressed));
        if (result_ch.touch_x !== want.touch_x)
          report_mismatch("touch_x", int'(result_ch.touch_x), int'(want.touch_x));
        if (result_ch.touch_y !== want.touch_y)
          report_mismatch("touch_y", int'(result_ch.touch_y), int'(want.touch_y));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst              <= 1'b1;
    sample_ch.valid  <= 1'b0;
    sample_ch.raw_x  <= '0;
    sample_ch.raw_y  <= '0;
    sample_ch.raw_z  <= '0;
    sample_ch.now_ms <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_calibration_sweep();
    test_sample_noise();
    test_result_backpressure();

    wait_idle();
    if (mismatches == 0)
      $display("touch_sample_qualify_and_map_core regression: pass");
    else
      $display("touch_sample_qualify_and_map_core regression: fail");
    $finish;
  end

endmodule

### touch_sample_qualify_and_map_core.f
+incdir+sv
sv/tsqm_pkg.sv
sv/tsqm_ifs.sv
sv/tsqm_div.sv
sv/touch_sample_qualify_and_map_core.sv
tb/sv/touch_sample_qualify_and_map_core_test.sv
